// File: design/mssf_pkg.sv
package mssf_pkg;

    localparam logic [15:0] EthertypeIpv4 = 16'h0800;
    localparam logic [7:0]  ProtoTcp      = 8'd6;
    localparam logic [15:0] BrokerPortRst = 16'd1883;
    localparam logic [29:0] TransRowRst   = 30'h3FFF_FFFF;

    localparam logic [1:0] CfgTransQ0 = 2'd0;
    localparam logic [1:0] CfgTransQ1 = 2'd1;
    localparam logic [1:0] CfgBroker  = 2'd2;

    localparam logic [2:0] RsnNone     = 3'd0;
    localparam logic [2:0] RsnTypeZero = 3'd1;
    localparam logic [2:0] RsnApproved = 3'd2;
    localparam logic [2:0] RsnBlocked  = 3'd3;
    localparam logic [2:0] RsnIllegal  = 3'd4;
    localparam logic [2:0] RsnUnmapped = 3'd5;

    localparam logic [1:0] StDisc  = 2'd0;
    localparam logic [1:0] StConn  = 2'd1;
    localparam logic [1:0] StError = 2'd2;
    localparam logic [1:0] StUnmap = 2'd3;

endpackage

// File: design/mssf_ram.sv
module mssf_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                         i_wdata,
    input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/mqtt_session_state_filter.sv
// A non-final byte is captured in the receive state. A final byte of an
// inspected frame of nonzero type walks the filled part of the session table,
// one entry per registered RAM read, then compare, then applies the transition
// before the result is shown. Other final bytes go from decide to the result.
// Throughput: one byte per cycle inside a frame; after a final byte the input
// waits until the verdict transaction completes.
// Reset (i_rst_n low, synchronous) clears captures, fill count and
// restores configuration defaults; session RAM contents are only compared below the fill count.
module mqtt_session_state_filter #(
    parameter int SESSIONS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic        s_axis_tlast,   // last_byte
    // verdict stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] verdict, [3:1] reason,
                                        // [5:4] client_state, [9:6] message_type
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);
    localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int CW = $clog2(SESSIONS + 1);

    typedef enum logic [2:0] {
        ST_RX, ST_DECIDE, ST_SEARCH, ST_CMP, ST_APPLY, ST_OUT
    } t_state;

    t_state r_state;

    logic [29:0] r_row_q0, r_row_q1;
    logic [15:0] r_broker;

    logic [15:0] r_cnt, r_etype, r_dport;
    logic [7:0]  r_proto, r_first;
    logic [3:0]  r_ihl, r_doff;
    logic [31:0] r_saddr;

    // entries below the fill count are the valid ones
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_idx;   // search index, may reach SESSIONS
    logic                r_hit;
    logic [AW-1:0]       r_slot;
    logic [1:0]          r_cur;
    logic                r_verdict_blk; // entry already in error: no store

    logic        r_verdict;
    logic [2:0]  r_reason;
    logic [1:0]  r_cstate;
    logic [3:0]  r_mtype;

    // RAM ports
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_addr_q;
    logic [1:0]    w_code_q;
    logic [1:0]    w_new;

    mssf_ram #(.Width(32), .Depth(SESSIONS)) u_addr_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_saddr),
        .i_raddr(w_raddr), .o_rdata(w_addr_q));
    mssf_ram #(.Width(2), .Depth(SESSIONS)) u_code_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_new),
        .i_raddr(w_raddr), .o_rdata(w_code_q));

    assign s_axis_tready = (r_state == ST_RX);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {6'd0, r_mtype, r_cstate, r_reason, r_verdict};

    // field capture positions
    logic [16:0] w_tcp, w_pay;
    logic        w_acc;
    logic [15:0] w_cnt1;
    assign w_tcp  = 17'd14 + {11'd0, r_ihl, 2'b00};
    assign w_pay  = w_tcp + {11'd0, r_doff, 2'b00};
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_cnt1 = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;

    // inspection test on the finished frame
    logic w_insp;
    assign w_insp = ({1'b0, r_cnt} >= 17'd34) && (r_etype == mssf_pkg::EthertypeIpv4)
        && (r_proto == mssf_pkg::ProtoTcp) && ({1'b0, r_cnt} >= w_tcp + 17'd20)
        && (r_dport == r_broker) && (r_doff >= 4'd3)
        && ({1'b0, r_cnt} >= w_pay + 17'd1);

    logic [29:0] w_row;
    logic [1:0]  w_nxt;
    assign w_row = (r_cur == mssf_pkg::StDisc) ? r_row_q0 : r_row_q1;
    assign w_nxt = 2'(w_row >> {r_mtype - 4'd1, 1'b0});

    // new client state; unmapped folds into error
    assign w_new = (w_nxt == mssf_pkg::StConn) ? mssf_pkg::StConn
                 : (w_nxt == mssf_pkg::StDisc) ? mssf_pkg::StDisc : mssf_pkg::StError;

    logic w_idx_in;
    assign w_idx_in = (r_idx < CW'(SESSIONS));
    assign w_raddr  = r_idx[AW-1:0];
    assign w_waddr  = r_hit ? r_slot : r_fill[AW-1:0];
    assign w_we     = (r_state == ST_APPLY) && !r_verdict_blk
        && (r_hit || r_fill < CW'(SESSIONS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RX;
            r_row_q0 <= mssf_pkg::TransRowRst;
            r_row_q1 <= mssf_pkg::TransRowRst;
            r_broker <= mssf_pkg::BrokerPortRst;
            r_cnt <= '0; r_etype <= '0; r_dport <= '0; r_proto <= '0;
            r_first <= '0; r_ihl <= '0; r_doff <= '0; r_saddr <= '0;
            r_fill  <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_slot  <= '0;
            r_cur   <= mssf_pkg::StDisc;
            r_verdict_blk <= 1'b0;
            r_verdict <= 1'b0;
            r_reason  <= mssf_pkg::RsnNone;
            r_cstate  <= mssf_pkg::StDisc;
            r_mtype   <= 4'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mssf_pkg::CfgTransQ0: r_row_q0 <= i_cfg_data;
                    mssf_pkg::CfgTransQ1: r_row_q1 <= i_cfg_data;
                    mssf_pkg::CfgBroker:  r_broker <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_RX: begin
                    if (w_acc) begin
                        if (r_cnt == 16'd12) r_etype <= {s_axis_tdata, 8'd0};
                        else if (r_cnt == 16'd13) r_etype[7:0] <= s_axis_tdata;
                        else if (r_cnt == 16'd14) r_ihl <= s_axis_tdata[3:0];
                        if (r_cnt == 16'd23) r_proto <= s_axis_tdata;
                        if (r_cnt >= 16'd26 && r_cnt <= 16'd29)
                            r_saddr <= {r_saddr[23:0], s_axis_tdata};
                        if (r_cnt > 16'd14) begin
                            if ({1'b0, r_cnt} == w_tcp + 17'd2)
                                r_dport <= {s_axis_tdata, 8'd0};
                            if ({1'b0, r_cnt} == w_tcp + 17'd3)
                                r_dport[7:0] <= s_axis_tdata;
                            if ({1'b0, r_cnt} == w_tcp + 17'd12)
                                r_doff <= s_axis_tdata[7:4];
                            // offset byte itself may be the payload start
                            if ({1'b0, r_cnt} == w_tcp + 17'd12
                                && s_axis_tdata[7:4] == 4'd3)
                                r_first <= s_axis_tdata;
                            else if ({1'b0, r_cnt} > w_tcp + 17'd12
                                && {1'b0, r_cnt} == w_pay)
                                r_first <= s_axis_tdata;
                        end
                        r_cnt <= w_cnt1;
                        if (s_axis_tlast) r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_verdict <= 1'b0;
                    r_cstate  <= mssf_pkg::StDisc;
                    r_idx     <= '0;
                    r_hit     <= 1'b0;
                    r_cur     <= mssf_pkg::StDisc;
                    if (w_insp) begin
                        r_mtype <= r_first[7:4];
                        if (r_first[7:4] == 4'd0) begin
                            r_reason <= mssf_pkg::RsnTypeZero;
                            r_state  <= ST_OUT;
                        end else begin
                            r_reason <= mssf_pkg::RsnNone;
                            r_state  <= ST_SEARCH;
                        end
                    end else begin
                        r_mtype  <= 4'd0;
                        r_reason <= mssf_pkg::RsnNone;
                        r_state  <= ST_OUT;
                    end
                end
                ST_SEARCH: begin
                    // RAM read of r_idx issued this cycle
                    if (!w_idx_in || r_idx >= r_fill) begin
                        r_state <= ST_APPLY;
                        r_verdict_blk <= 1'b0;
                    end else begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (w_addr_q == r_saddr) begin
                        r_hit  <= 1'b1;
                        r_slot <= r_idx[AW-1:0];
                        r_cur  <= w_code_q;
                        r_state <= ST_APPLY;
                        r_verdict_blk <= (w_code_q >= mssf_pkg::StError);
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_SEARCH;
                    end
                end
                ST_APPLY: begin
                    r_state <= ST_OUT;
                    if (r_verdict_blk) begin
                        r_verdict <= 1'b1;
                        r_reason  <= mssf_pkg::RsnBlocked;
                        r_cstate  <= mssf_pkg::StError;
                    end else begin
                        r_cstate  <= w_new;
                        r_verdict <= (w_nxt >= mssf_pkg::StError);
                        r_reason  <= (w_nxt == mssf_pkg::StUnmap) ? mssf_pkg::RsnUnmapped
                                   : (w_nxt == mssf_pkg::StError) ? mssf_pkg::RsnIllegal
                                   : mssf_pkg::RsnApproved;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= ST_RX;
                        r_cnt <= '0; r_etype <= '0; r_dport <= '0; r_proto <= '0;
                        r_first <= '0; r_ihl <= '0; r_doff <= '0; r_saddr <= '0;
                    end
                end
                default: r_state <= ST_RX;
            endcase
            // a new client takes the next free entry
            if (w_we && !r_hit) begin
                r_fill <= r_fill + CW'(1);
            end
        end
    end
endmodule

// File: bench/mqtt_session_state_filter_tb.sv
`timescale 1ns / 1ps

module mqtt_session_state_filter_tb;

    localparam int SESSIONS   = 8;
    localparam int HOLD_OFF   = SESSIONS + 16;  // worst lookup plus margin
    localparam int WD_LIMIT   = 1000;           // cycles with no transaction

    typedef bit [7:0] t_byte_q[$];

    // one verdict as it leaves the block
    typedef struct packed {
        bit       drop;
        bit [2:0] reason;
        bit [1:0] cstate;
        bit [3:0] mtype;
    } t_verdict;

    // shape of one frame; payload sits at tcp start + 4*doff
    typedef struct {
        bit [15:0] eth;
        bit [3:0]  ihl;
        bit [7:0]  proto;
        bit [31:0] src;
        bit [15:0] dport;
        bit [3:0]  doff;
        bit [7:0]  mbyte;
        int        extra;
        int        trunc;     // 0 keeps the full length
        bit        pinned;    // expected verdict typed in below
        t_verdict  pin;
    } t_frame;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [29:0] i_cfg_data;

    mqtt_session_state_filter #(.SESSIONS(SESSIONS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Filter model: register copies, per-frame captures, session table
    // ---------------------------------------------------------------
    bit [29:0] row_disc, row_conn;
    bit [15:0] port_sel;
    bit [15:0] fr_count, fr_eth, fr_dport;
    bit [7:0]  fr_proto, fr_pay;
    bit [3:0]  fr_ihl, fr_doff;
    bit [31:0] fr_src;
    bit [31:0] sess_addr [SESSIONS];
    bit [1:0]  sess_code [SESSIONS];
    bit        sess_vld  [SESSIONS];
    int        sess_fill;

    t_verdict  verdicts_due[$];
    bit        pin_armed;
    t_verdict  pin_val;

    int errors, bytes_in, frames_out, frames_sent, table_full_hits;
    int idle_pct, stall_pct, quiet_cycles;

    function automatic void clear_captures();
        fr_count = '0; fr_eth = '0; fr_dport = '0; fr_proto = '0;
        fr_pay = '0; fr_ihl = '0; fr_doff = '0; fr_src = '0;
    endfunction

    function automatic void filter_byte(bit [7:0] b, bit last);
        int unsigned n, t, len, ev, cur, nxt;
        int slot;
        bit inspect;
        bit [29:0] row;
        t_verdict v;
        n = fr_count;
        if (n == 12) fr_eth = {b, 8'h00};
        else if (n == 13) fr_eth = fr_eth | b;
        else if (n == 14) fr_ihl = b[3:0];
        if (n == 23) fr_proto = b;
        if (n >= 26 && n <= 29) fr_src = {fr_src[23:0], b};
        if (n > 14) begin
            t = 14 + 4 * fr_ihl;
            if (n == t + 2) fr_dport = {b, 8'h00};
            if (n == t + 3) fr_dport = fr_dport | b;
            if (n == t + 12) fr_doff = b[7:4];
            if (n >= t + 12 && n == t + 4 * fr_doff) fr_pay = b;
        end
        if (fr_count != 16'hFFFF) fr_count++;
        if (!last) return;

        v = '0;
        len = fr_count;
        t = 14 + 4 * fr_ihl;
        inspect = len >= 34 && fr_eth == mssf_pkg::EthertypeIpv4 &&
                  fr_proto == mssf_pkg::ProtoTcp &&
                  len >= t + 20 && fr_dport == port_sel && fr_doff >= 3 &&
                  len >= t + 4 * fr_doff + 1;
        if (inspect) begin
            ev = fr_pay[7:4];
            v.mtype = 4'(ev);
            if (ev == 0) begin
                v.reason = mssf_pkg::RsnTypeZero;
            end else begin
                slot = -1;
                cur = mssf_pkg::StDisc;
                for (int i = 0; i < SESSIONS; i++) begin
                    if (sess_vld[i] && sess_addr[i] == fr_src) begin
                        slot = i;
                        cur = sess_code[i];
                        break;
                    end
                end
                if (cur >= mssf_pkg::StError) begin
                    // error, or a stored code of 3, stays blocked
                    v = '{1'b1, mssf_pkg::RsnBlocked, mssf_pkg::StError, 4'(ev)};
                end else begin
                    row = (cur == mssf_pkg::StDisc) ? row_disc : row_conn;
                    nxt = (row >> (2 * (ev - 1))) & 3;
                    if (nxt == mssf_pkg::StUnmap)
                        v = '{1'b1, mssf_pkg::RsnUnmapped, mssf_pkg::StError, 4'(ev)};
                    else if (nxt == mssf_pkg::StError)
                        v = '{1'b1, mssf_pkg::RsnIllegal, mssf_pkg::StError, 4'(ev)};
                    else
                        v = '{1'b0, mssf_pkg::RsnApproved, 2'(nxt), 4'(ev)};
                    if (slot >= 0) begin
                        sess_code[slot] = v.cstate;
                    end else if (sess_fill < SESSIONS) begin
                        sess_addr[sess_fill] = fr_src;
                        sess_code[sess_fill] = v.cstate;
                        sess_vld[sess_fill]  = 1'b1;
                        sess_fill++;
                    end else begin
                        table_full_hits++;
                    end
                end
            end
        end
        clear_captures();
        if (pin_armed) begin
            v = pin_val;
            pin_armed = 1'b0;
        end
        verdicts_due.push_back(v);
    endfunction

    // ---------------------------------------------------------------
    // Transaction monitor, scoreboard and watchdog
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict got, want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            moved = 1'b1;
            case (i_cfg_index)
                mssf_pkg::CfgTransQ0: row_disc = i_cfg_data;
                mssf_pkg::CfgTransQ1: row_conn = i_cfg_data;
                mssf_pkg::CfgBroker:  port_sel = i_cfg_data[15:0];
                default: ;
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved = 1'b1;
            bytes_in++;
            filter_byte(s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            frames_out++;
            got = {m_axis_tdata[0], m_axis_tdata[3:1], m_axis_tdata[5:4],
                   m_axis_tdata[9:6]};
            if (verdicts_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: verdict with none pending: %h", $realtime, got);
            end else begin
                want = verdicts_due.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"%0t: mismatch drop %0d/%0d reason %0d/%0d ",
                                  "state %0d/%0d type %0d/%0d (exp/act)"},
                                 $realtime, want.drop, got.drop, want.reason, got.reason,
                                 want.cstate, got.cstate, want.mtype, got.mtype);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog: no transaction in %0d cycles", WD_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic send_byte(bit [7:0] b, bit last);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_byte_q frame_bytes(t_frame f);
        t_byte_q q;
        int t, len, pay;
        t = 14 + 4 * f.ihl;
        pay = t + 4 * f.doff;
        len = (pay + 1 > t + 20) ? pay + 1 : t + 20;
        len += f.extra;
        for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(0, 255)));
        q[12] = f.eth[15:8];
        q[13] = f.eth[7:0];
        q[14] = {4'h4, f.ihl};
        q[23] = f.proto;
        for (int i = 0; i < 4; i++) q[26 + i] = f.src[31 - 8 * i -: 8];
        q[t + 2]  = f.dport[15:8];
        q[t + 3]  = f.dport[7:0];
        q[t + 12] = {f.doff, q[t + 12][3:0]};
        if (f.doff >= 3) q[pay] = f.mbyte;
        if (f.trunc > 0 && f.trunc < len) q = q[0 : f.trunc - 1];
        return q;
    endfunction

    task automatic send_frame(t_frame f);
        t_byte_q q;
        q = frame_bytes(f);
        if (f.pinned) begin
            pin_armed = 1'b1;
            pin_val = f.pin;
        end
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
        frames_sent++;
    endtask

    // sender pauses until every verdict is back
    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (verdicts_due.size() != 0 && guard < 100 * WD_LIMIT);
    endtask

    // registers change only when idle
    task automatic write_regs(bit [29:0] q0, bit [29:0] q1, bit [15:0] port);
        drain();
        repeat (HOLD_OFF) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (i == 0) ? mssf_pkg::CfgTransQ0
                         : (i == 1) ? mssf_pkg::CfgTransQ1 : mssf_pkg::CfgBroker;
            i_cfg_data  <= (i == 0) ? q0 : (i == 1) ? q1 : {14'h0, port};
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_frame mqtt_frame(bit [31:0] src, bit [15:0] port, bit [7:0] mb);
        t_frame f;
        f = '{mssf_pkg::EthertypeIpv4, 4'd5, mssf_pkg::ProtoTcp, src, port, 4'd5, mb,
              0, 0, 1'b0, '0};
        return f;
    endfunction

    bit [31:0] client_pool[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001,
                                  32'h0A00_0002, 32'h7F00_0001, 32'hAC10_3C05};

    // mostly well-formed traffic for a handful of clients, some noise
    task automatic random_phase(int n_bytes, int n_verdicts);
        int b0, v0, r;
        t_frame f;
        b0 = bytes_in;
        v0 = frames_out;
        while (bytes_in - b0 < n_bytes || frames_out - v0 < n_verdicts) begin
            f = mqtt_frame(client_pool[$urandom_range(0, 5)], port_sel,
                           8'($urandom_range(0, 255)));
            f.extra = $urandom_range(0, 6);
            r = $urandom_range(0, 99);
            if (r < 8)       f.ihl   = 4'($urandom_range(0, 15));
            else if (r < 14) f.doff  = 4'($urandom_range(0, 15));
            else if (r < 18) f.eth   = 16'($urandom_range(0, 65535));
            else if (r < 22) f.proto = 8'($urandom_range(0, 255));
            else if (r < 26) f.dport = 16'($urandom_range(0, 65535));
            else if (r < 32) f.trunc = $urandom_range(1, 60);
            send_frame(f);
        end
    endtask

    // ---------------------------------------------------------------
    // Directed frames, run with reset registers (all transitions unmapped)
    // ---------------------------------------------------------------
    localparam int N_DIR = 11;
    t_frame dir_tbl[N_DIR];

    initial begin
        t_frame f;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = mssf_pkg::CfgTransQ0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        idle_pct = 0; stall_pct = 0;
        errors = 0; bytes_in = 0; frames_out = 0; frames_sent = 0;
        table_full_hits = 0; quiet_cycles = 0;
        pin_armed = 1'b0;
        row_disc = mssf_pkg::TransRowRst;
        row_conn = mssf_pkg::TransRowRst;
        port_sel = mssf_pkg::BrokerPortRst;
        sess_fill = 0;
        foreach (sess_vld[i]) sess_vld[i] = 1'b0;
        clear_captures();

        // non-IPv4: passed, not inspected
        dir_tbl[0] = mqtt_frame(32'h0101_0101, mssf_pkg::BrokerPortRst, 8'h10);
        dir_tbl[0].eth = 16'h86DD;
        dir_tbl[0].pinned = 1'b1;
        dir_tbl[0].pin = '{1'b0, mssf_pkg::RsnNone, mssf_pkg::StDisc, 4'd0};
        // UDP
        dir_tbl[1] = mqtt_frame(32'h0101_0101, mssf_pkg::BrokerPortRst, 8'h10);
        dir_tbl[1].proto = 8'd17;
        dir_tbl[1].pinned = 1'b1;
        dir_tbl[1].pin = '{1'b0, mssf_pkg::RsnNone, mssf_pkg::StDisc, 4'd0};
        // other port
        dir_tbl[2] = mqtt_frame(32'h0101_0101, 16'd80, 8'h10);
        dir_tbl[2].pinned = 1'b1;
        dir_tbl[2].pin = '{1'b0, mssf_pkg::RsnNone, mssf_pkg::StDisc, 4'd0};
        // too short, single byte
        dir_tbl[3] = mqtt_frame(32'h0101_0101, mssf_pkg::BrokerPortRst, 8'h10);
        dir_tbl[3].trunc = 1;
        dir_tbl[3].pinned = 1'b1;
        dir_tbl[3].pin = '{1'b0, mssf_pkg::RsnNone, mssf_pkg::StDisc, 4'd0};
        // type zero, no lookup
        dir_tbl[4] = mqtt_frame(32'hFFFF_FFFF, mssf_pkg::BrokerPortRst, 8'h0F);
        dir_tbl[4].pinned = 1'b1;
        dir_tbl[4].pin = '{1'b0, mssf_pkg::RsnTypeZero, mssf_pkg::StDisc, 4'd0};
        // fresh client, unmapped event
        dir_tbl[5] = mqtt_frame(32'hFFFF_FFFF, mssf_pkg::BrokerPortRst, 8'h10);
        dir_tbl[5].pinned = 1'b1;
        dir_tbl[5].pin = '{1'b1, mssf_pkg::RsnUnmapped, mssf_pkg::StError, 4'd1};
        // same client now blocked
        dir_tbl[6] = mqtt_frame(32'hFFFF_FFFF, mssf_pkg::BrokerPortRst, 8'hF0);
        dir_tbl[6].pinned = 1'b1;
        dir_tbl[6].pin = '{1'b1, mssf_pkg::RsnBlocked, mssf_pkg::StError, 4'd15};
        // short data offset, short IHL, IHL extreme, offset extreme
        dir_tbl[7] = mqtt_frame(32'h0000_0000, mssf_pkg::BrokerPortRst, 8'h20);
        dir_tbl[7].doff = 4'd2;
        dir_tbl[8] = mqtt_frame(32'h0000_0000, mssf_pkg::BrokerPortRst, 8'h20);
        dir_tbl[8].ihl = 4'd3;
        dir_tbl[9] = mqtt_frame(32'h0000_0000, mssf_pkg::BrokerPortRst, 8'h30);
        dir_tbl[9].ihl = 4'd15;
        dir_tbl[10] = mqtt_frame(32'h0000_0001, mssf_pkg::BrokerPortRst, 8'hE0);
        dir_tbl[10].doff = 4'd15;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            send_frame(dir_tbl[i]);
            drain();
        end

        // random rows, default port, sender idles
        idle_pct = 77; stall_pct = 0;
        write_regs(30'($urandom_range(0, 30'h3FFF_FFFF)),
                   30'($urandom_range(0, 30'h3FFF_FFFF)), mssf_pkg::BrokerPortRst);
        random_phase(150, 3);

        // everything approved back to disconnected, top port, receiver stalls
        idle_pct = 0; stall_pct = 77;
        write_regs('0, '0, 16'hFFFF);
        random_phase(80, 2);
        drain();
        random_phase(80, 2);

        // unmapped from disconnected, connected stays connected, port zero
        idle_pct = 19; stall_pct = 19;
        write_regs(30'h3FFF_FFFF, 30'h1555_5555, 16'h0000);
        random_phase(150, 3);

        // every event connects; new clients beyond table capacity
        idle_pct = 0; stall_pct = 0;
        write_regs(30'h1555_5555, 30'($urandom_range(0, 30'h3FFF_FFFF)),
                   mssf_pkg::BrokerPortRst);
        for (int i = 0; i < 4; i++) begin
            f = mqtt_frame(32'h0B00_0000 + i, mssf_pkg::BrokerPortRst,
                           {4'($urandom_range(1, 15)), 4'h0});
            send_frame(f);
        end

        drain();
        repeat (HOLD_OFF) @(posedge i_clk);

        $display("frames sent %0d, bytes %0d, verdicts %0d, session entries %0d",
                 frames_sent, bytes_in, frames_out, sess_fill);
        $display("new clients refused on a full table: %0d", table_full_hits);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d errors, %0d verdicts missing", errors, verdicts_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/mssf_pkg.sv
design/mssf_ram.sv
design/mqtt_session_state_filter.sv
bench/mqtt_session_state_filter_tb.sv
